// ===== rtl/fac_pkg.sv =====
// Package for the frame averaging accumulator.
// Shared constants, controller states, command/status structs and the pixel narrowing function.
// No dependencies.
package fac_pkg;

    localparam int MAX_FRAME_PIXELS_DEF   = 1048576;
    localparam int MAX_AVERAGE_FACTOR_DEF = 1024;

    localparam int SAMPLE_W    = 32;
    localparam int PIX_IDX_W   = 20;
    localparam int FACTOR_W    = 11;
    localparam int FRAME_W     = 21;
    localparam int WCODE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 21;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PIXELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_WIDTH  = 2'd2;

    // pixel width codes
    localparam logic [WCODE_W-1:0] WC_BYTE = 2'd0;
    localparam logic [WCODE_W-1:0] WC_HALF = 2'd1;
    localparam logic [WCODE_W-1:0] WC_WORD = 2'd2;

    localparam logic [FACTOR_W-1:0] FACTOR_RST = 11'd1;
    localparam logic [FRAME_W-1:0]  FRAME_RST  = 21'd1048576;
    localparam logic [WCODE_W-1:0]  WCODE_RST  = WC_HALF;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic load_item;   // word accepted: latch sample, read sum
        logic acc;         // write new sum, step counters
        logic div_start;   // hand new sum to divider
        logic load_out;    // move quotient into output register
    } t_cmd;

    typedef struct packed {
        logic last_frame;
        logic div_done;
        logic out_free;
    } t_status;

    // Sign-extend the low 8, 16 or 32 bits; code 3 counts as four bytes.
    function automatic logic [SAMPLE_W-1:0] narrow(input logic [SAMPLE_W-1:0] v,
                                                   input logic [WCODE_W-1:0] code);
        logic [SAMPLE_W-1:0] r;
        case (code)
            WC_BYTE: r = {{(SAMPLE_W-8){v[7]}}, v[7:0]};
            WC_HALF: r = {{(SAMPLE_W-16){v[15]}}, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/fac_if.sv =====
// Stream interfaces of the frame averaging accumulator: sample in, averaged pixel out.
// Depends on fac_pkg.
interface fac_in_if;
    logic                            valid;
    logic                            ready;
    logic [fac_pkg::SAMPLE_W-1:0]    sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface fac_out_if;
    logic                            valid;
    logic                            ready;
    logic [fac_pkg::SAMPLE_W-1:0]    average;
    logic [fac_pkg::PIX_IDX_W-1:0]   pixel_index;
    logic                            frame_end;

    modport source (output valid, output average, output pixel_index, output frame_end,
                    input ready);
    modport sink   (input valid, input average, input pixel_index, input frame_end,
                    output ready);
endinterface

// ===== rtl/fac_div.sv =====
// Restoring divider, one quotient bit per clock, signed dividend by positive divisor.
// Quotient truncates toward zero. Depends on nothing outside itself.
module fac_div #(
    parameter int SUM_W = 42,
    parameter int FAC_W = 11
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [FAC_W-1:0]        i_divisor,
    output logic                    o_done,
    output logic signed [SUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] r_quo, n_quo;
    logic [FAC_W-1:0] r_rem, n_rem;
    logic [FAC_W-1:0] r_dvs;
    logic             r_neg;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [FAC_W:0]   shifted;
    logic [FAC_W:0]   trial;

    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        trial   = shifted - {1'b0, r_dvs};
        if (!trial[FAC_W]) begin
            n_rem = trial[FAC_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[FAC_W-1:0];
            n_quo = {r_quo[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= CNT_W'(SUM_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_cnt != '0) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -signed'(r_quo) : signed'(r_quo);

endmodule

// ===== rtl/fac_ctrl.sv =====
// Controller of the frame averaging accumulator: sequences accept, accumulate, divide, output.
// Depends on fac_pkg.
module fac_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  fac_pkg::t_status i_status,
    output logic             o_in_ready,
    output fac_pkg::t_cmd    o_cmd
);
    fac_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fac_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fac_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = fac_pkg::ST_ACC;
                end
            end
            fac_pkg::ST_ACC: begin
                n_state = i_status.last_frame ? fac_pkg::ST_DIV : fac_pkg::ST_IDLE;
            end
            fac_pkg::ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = fac_pkg::ST_LOAD;
                end
            end
            fac_pkg::ST_LOAD: begin
                if (i_status.out_free) begin
                    n_state = fac_pkg::ST_IDLE;
                end
            end
            default: n_state = fac_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            fac_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            fac_pkg::ST_ACC: begin
                o_cmd.acc       = 1'b1;
                o_cmd.div_start = i_status.last_frame;
            end
            fac_pkg::ST_LOAD: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/fac_dpath.sv =====
// Datapath of the frame averaging accumulator: configuration, counters, sum memory,
// divider and output register. Depends on fac_pkg and fac_div.
module fac_dpath #(
    parameter int MAX_FRAME_PIXELS   = fac_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int MAX_AVERAGE_FACTOR = fac_pkg::MAX_AVERAGE_FACTOR_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fac_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic [fac_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_out_ready,
    input  fac_pkg::t_cmd                    i_cmd,
    output fac_pkg::t_status                 o_status,
    output logic                             o_out_valid,
    output logic [fac_pkg::SAMPLE_W-1:0]     o_average,
    output logic [fac_pkg::PIX_IDX_W-1:0]    o_pixel_index,
    output logic                             o_frame_end
);
    localparam int POS_W = (MAX_FRAME_PIXELS > 1) ? $clog2(MAX_FRAME_PIXELS) : 1;
    localparam int FIG_W = (MAX_AVERAGE_FACTOR > 1) ? $clog2(MAX_AVERAGE_FACTOR) : 1;
    localparam int FAC_W = $clog2(MAX_AVERAGE_FACTOR + 1);
    localparam int FS_W  = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int SUM_W = fac_pkg::SAMPLE_W + $clog2(MAX_AVERAGE_FACTOR);

    // configuration
    logic [fac_pkg::FACTOR_W-1:0] r_factor;
    logic [fac_pkg::FRAME_W-1:0]  r_frame_px;
    logic [fac_pkg::WCODE_W-1:0]  r_wcode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor   <= fac_pkg::FACTOR_RST;
            r_frame_px <= fac_pkg::FRAME_RST;
            r_wcode    <= fac_pkg::WCODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fac_pkg::CFG_AVG_FACTOR:   r_factor   <= i_cfg_data[fac_pkg::FACTOR_W-1:0];
                fac_pkg::CFG_FRAME_PIXELS: r_frame_px <= i_cfg_data[fac_pkg::FRAME_W-1:0];
                fac_pkg::CFG_PIXEL_WIDTH:  r_wcode    <= i_cfg_data[fac_pkg::WCODE_W-1:0];
                default: ;
            endcase
        end
    end

    // effective factor and frame size, clamped to 1..max
    logic [FAC_W-1:0] fac_eff;
    logic [FS_W-1:0]  fs_eff;

    always_comb begin
        if (r_factor == '0) begin
            fac_eff = FAC_W'(1);
        end else if (32'(r_factor) > 32'(MAX_AVERAGE_FACTOR)) begin
            fac_eff = FAC_W'(MAX_AVERAGE_FACTOR);
        end else begin
            fac_eff = FAC_W'(r_factor);
        end
        if (r_frame_px == '0) begin
            fs_eff = FS_W'(1);
        end else if (32'(r_frame_px) > 32'(MAX_FRAME_PIXELS)) begin
            fs_eff = FS_W'(MAX_FRAME_PIXELS);
        end else begin
            fs_eff = FS_W'(r_frame_px);
        end
    end

    // position counters
    logic [POS_W-1:0] r_pos;
    logic [FIG_W-1:0] r_fig;
    logic             last_pixel;
    logic             last_frame;

    assign last_pixel = (32'(r_pos) + 32'd1) >= 32'(fs_eff);
    assign last_frame = (32'(r_fig) + 32'd1) >= 32'(fac_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_fig <= '0;
        end else if (i_cmd.acc) begin
            if (last_pixel) begin
                r_pos <= '0;
                r_fig <= last_frame ? '0 : r_fig + FIG_W'(1);
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // item latch
    logic signed [fac_pkg::SAMPLE_W-1:0] r_sample;
    logic                                r_first;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sample <= signed'(fac_pkg::narrow(i_sample, r_wcode));
            r_first  <= (r_fig == '0);
        end
    end

    // sum memory, read on accept, written on accumulate
    logic signed [SUM_W-1:0] mem [MAX_FRAME_PIXELS];
    logic signed [SUM_W-1:0] r_rd;
    logic signed [SUM_W-1:0] n_sum;

    assign n_sum = r_first ? SUM_W'(r_sample) : r_rd + SUM_W'(r_sample);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_rd <= mem[r_pos];
        end
        if (i_cmd.acc) begin
            mem[r_pos] <= n_sum;
        end
    end

    // result tag held while dividing
    logic [fac_pkg::PIX_IDX_W-1:0] r_idx;
    logic                          r_fend;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc) begin
            r_idx  <= fac_pkg::PIX_IDX_W'(r_pos);
            r_fend <= last_pixel;
        end
    end

    logic                    div_done;
    logic signed [SUM_W-1:0] quot;

    fac_div #(
        .SUM_W (SUM_W),
        .FAC_W (FAC_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_sum),
        .i_divisor  (fac_eff),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // output register
    logic                          r_out_valid;
    logic [fac_pkg::SAMPLE_W-1:0]  r_avg;
    logic [fac_pkg::PIX_IDX_W-1:0] r_idx_out;
    logic                          r_fend_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_avg      <= fac_pkg::narrow(quot[fac_pkg::SAMPLE_W-1:0], r_wcode);
            r_idx_out  <= r_idx;
            r_fend_out <= r_fend;
        end
    end

    assign o_status.last_frame = last_frame;
    assign o_status.div_done   = div_done;
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_average     = r_avg;
    assign o_pixel_index = r_idx_out;
    assign o_frame_end   = r_fend_out;

endmodule

// ===== rtl/frame_averaging_accumulator.sv =====
// Top level of the frame averaging accumulator: controller plus datapath.
// Depends on fac_pkg, fac_if, fac_ctrl, fac_dpath (with fac_div).
//
//   port     dir   handshake     carries
//   i_pix    in    valid/ready   sample
//   o_avg    out   valid/ready   average, pixel_index, frame_end
//   i_cfg_*  in    write enable  register index, data
//
// One word at a time: a word of a non-final frame passes accept, then
// read-add-write of the sum memory; a word of the last frame of a run also
// passes the one-bit-per-clock divider of SUM_W = 32 + clog2(MAX_AVERAGE_FACTOR)
// bits (42 at default) and the output load. Synchronous reset clears the
// counters and registers; the sum memory is not cleared. A stalled output holds
// one result while the next word is accepted and summed.
module frame_averaging_accumulator #(
    parameter int MAX_FRAME_PIXELS   = fac_pkg::MAX_FRAME_PIXELS_DEF,
    parameter int MAX_AVERAGE_FACTOR = fac_pkg::MAX_AVERAGE_FACTOR_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    fac_in_if.sink                         i_pix,
    fac_out_if.source                      o_avg,
    input  logic                           i_cfg_we,
    input  logic [fac_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fac_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    fac_pkg::t_cmd    cmd;
    fac_pkg::t_status status;

    fac_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .i_status   (status),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd)
    );

    fac_dpath #(
        .MAX_FRAME_PIXELS   (MAX_FRAME_PIXELS),
        .MAX_AVERAGE_FACTOR (MAX_AVERAGE_FACTOR)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_pix.sample),
        .i_out_ready   (o_avg.ready),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_out_valid   (o_avg.valid),
        .o_average     (o_avg.average),
        .o_pixel_index (o_avg.pixel_index),
        .o_frame_end   (o_avg.frame_end)
    );

endmodule

// ===== dv/fac_checker.sv =====
// Scoreboard for the frame averaging accumulator: tracks register writes, sums every
// accepted sample word per pixel and checks each averaged pixel against its prediction.
// Depends on fac_pkg and fac_if.
module fac_checker import fac_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fac_in_if                     i_pix,
    fac_out_if                    i_avg,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output logic                  o_mid_run
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [SAMPLE_W-1:0]  average;
        logic [PIX_IDX_W-1:0] pixel_index;
        logic                 frame_end;
    } t_avg_pixel;

    // expected pixels in order, written at the tail and taken from the head
    t_avg_pixel          expected_pixels[int unsigned];
    int unsigned         exp_head;
    int unsigned         exp_tail;
    longint              pixel_sums[int unsigned];
    logic [FACTOR_W-1:0] factor_reg;
    logic [FRAME_W-1:0]  frame_reg;
    logic [WCODE_W-1:0]  wcode_reg;
    int unsigned         pixel_pos;
    int unsigned         frame_in_run;
    int                  err_count;
    int                  result_count;

    function automatic longint widen(input logic [SAMPLE_W-1:0] v,
                                     input logic [WCODE_W-1:0] code);
        case (code)
            WC_BYTE: return longint'($signed(v[7:0]));
            WC_HALF: return longint'($signed(v[15:0]));
            default: return longint'($signed(v));
        endcase
    endfunction

    task automatic accumulate(input logic [SAMPLE_W-1:0] sample);
        longint     factor;
        longint     frame_len;
        longint     s;
        longint     quo;
        longint     narrowed;
        int unsigned slot;
        bit         last_pix;
        bit         last_frame;
        t_avg_pixel exp_px;
        factor = (factor_reg == '0) ? 64'sd1 : longint'(factor_reg);
        if (factor > MAX_AVERAGE_FACTOR_DEF) factor = MAX_AVERAGE_FACTOR_DEF;
        frame_len = (frame_reg == '0) ? 64'sd1 : longint'(frame_reg);
        if (frame_len > MAX_FRAME_PIXELS_DEF) frame_len = MAX_FRAME_PIXELS_DEF;
        s    = widen(sample, wcode_reg);
        slot = pixel_pos;
        // first frame of a run overwrites the sum
        if (frame_in_run == 0 || !pixel_sums.exists(slot)) begin
            pixel_sums[slot] = s;
        end else begin
            pixel_sums[slot] += s;
        end
        // counters may already be past the limits after a register write
        last_pix   = longint'(pixel_pos) + 1 >= frame_len;
        last_frame = longint'(frame_in_run) + 1 >= factor;
        if (last_pix) begin
            pixel_pos    = 0;
            frame_in_run = last_frame ? 0 : frame_in_run + 1;
        end else begin
            pixel_pos++;
        end
        if (last_frame) begin
            quo                = pixel_sums[slot] / factor;
            narrowed           = widen(quo[SAMPLE_W-1:0], wcode_reg);
            exp_px.average     = narrowed[SAMPLE_W-1:0];
            exp_px.pixel_index = slot[PIX_IDX_W-1:0];
            exp_px.frame_end   = last_pix;
            expected_pixels[exp_tail] = exp_px;
            exp_tail++;
        end
    endtask

    task automatic check_pixel();
        t_avg_pixel exp_px;
        result_count++;
        if (exp_tail == exp_head) begin
            err_count++;
            $display("%0t: averaged pixel with none expected, got average %0d index %0d end %0b",
                     $time, $signed(i_avg.average), i_avg.pixel_index, i_avg.frame_end);
        end else begin
            exp_px = expected_pixels[exp_head];
            expected_pixels.delete(exp_head);
            exp_head++;
            if (i_avg.average !== exp_px.average) begin
                err_count++;
                $display("%0t: average expected %0d, got %0d", $time,
                         $signed(exp_px.average), $signed(i_avg.average));
            end
            if (i_avg.pixel_index !== exp_px.pixel_index) begin
                err_count++;
                $display("%0t: pixel index expected %0d, got %0d", $time,
                         exp_px.pixel_index, i_avg.pixel_index);
            end
            if (i_avg.frame_end !== exp_px.frame_end) begin
                err_count++;
                $display("%0t: frame end expected %0b, got %0b", $time,
                         exp_px.frame_end, i_avg.frame_end);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            factor_reg   = FACTOR_RST;
            frame_reg    = FRAME_RST;
            wcode_reg    = WCODE_RST;
            pixel_pos    = 0;
            frame_in_run = 0;
            err_count    = 0;
            result_count = 0;
            exp_head     = 0;
            exp_tail     = 0;
            expected_pixels.delete();
            pixel_sums.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AVG_FACTOR:   factor_reg = i_cfg_data[FACTOR_W-1:0];
                    CFG_FRAME_PIXELS: frame_reg  = i_cfg_data[FRAME_W-1:0];
                    CFG_PIXEL_WIDTH:  wcode_reg  = i_cfg_data[WCODE_W-1:0];
                    default: ;
                endcase
            end
            // output first: a word accepted now cannot have its result out yet
            if (i_avg.valid && i_avg.ready) check_pixel();
            if (i_pix.valid && i_pix.ready) accumulate(i_pix.sample);
        end
        o_errors  <= err_count;
        o_pending <= int'(exp_tail - exp_head);
        o_results <= result_count;
        o_mid_run <= (frame_in_run != 0);
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the frame averaging accumulator bench: clock, reset, register writes,
// sample words and output back-pressure. Checking lives in fac_checker.
// Depends on fac_pkg, fac_if, fac_checker and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import fac_pkg::*;

    localparam int DRAIN_CYCLES    = 64;    // longer than one last-frame word
    localparam int TOTAL_WORDS     = 1950;
    localparam int CALM_WORDS      = 150;
    localparam int MAX_PHASE_WORDS = 150;
    localparam int END_LIMIT       = 20000;
    localparam int RND_FRAME_MAX   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
    localparam logic [WCODE_W-1:0]   WC_WORD_ALT = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    err_total;
    int                    pending;
    int                    results;
    logic                  mid_run;

    logic [CFG_DATA_W-1:0] cur_factor;
    logic [CFG_DATA_W-1:0] cur_frame;
    logic [WCODE_W-1:0]    cur_wcode;
    int                    words_sent;
    int                    settings_used;
    bit                    calm;

    fac_in_if  u_pix_if();
    fac_out_if u_avg_if();

    frame_averaging_accumulator u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (u_pix_if),
        .o_avg      (u_avg_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fac_checker u_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pix      (u_pix_if),
        .i_avg      (u_avg_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (err_total),
        .o_pending  (pending),
        .o_results  (results),
        .o_mid_run  (mid_run)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #10ms;
        $display("Regression FAIL");
        $finish;
    end

    // output back-pressure
    initial begin
        u_avg_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                u_avg_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
            end
            u_avg_if.ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12)) @(posedge clk);
        end
    end

    function automatic int eff_factor(input logic [CFG_DATA_W-1:0] v);
        int f;
        f = int'(v[FACTOR_W-1:0]);
        if (f == 0) f = 1;
        if (f > MAX_AVERAGE_FACTOR_DEF) f = MAX_AVERAGE_FACTOR_DEF;
        return f;
    endfunction

    function automatic int eff_frame(input logic [CFG_DATA_W-1:0] v);
        int n;
        n = int'(v[FRAME_W-1:0]);
        if (n == 0) n = 1;
        if (n > MAX_FRAME_PIXELS_DEF) n = MAX_FRAME_PIXELS_DEF;
        return n;
    endfunction

    // random word, biased to the sign boundaries of the active width
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [WCODE_W-1:0] code);
        logic [SAMPLE_W-1:0] mask;
        logic [SAMPLE_W-1:0] v;
        mask = (code == WC_BYTE) ? 32'h0000_00FF :
               (code == WC_HALF) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
        v = $urandom;
        case ($urandom_range(0, 7))
            0: v = (v & ~mask) | (mask >> 1);
            1: v = (v & ~mask) | ((mask >> 1) + 1);
            2: v = (v & ~mask) | (mask & ($urandom_range(0, 6) - 3));
            3: v = v | mask;
            default: ;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_AVG_FACTOR:   cur_factor = data;
            CFG_FRAME_PIXELS: cur_frame  = data;
            CFG_PIXEL_WIDTH:  cur_wcode  = data[WCODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_word(input logic [SAMPLE_W-1:0] v);
        calm = (words_sent >= TOTAL_WORDS - CALM_WORDS);
        if (!calm && $urandom_range(0, 4) == 0) begin
            u_pix_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        u_pix_if.valid  <= 1'b1;
        u_pix_if.sample <= v;
        do @(posedge clk); while (!u_pix_if.ready);
        words_sent++;
    endtask

    task automatic wait_results();
        u_pix_if.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // block idle: nothing owed and the last non-final word written back
    task automatic settle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int                    f;
        int                    n;
        int                    count;
        int                    r;
        logic [CFG_DATA_W-1:0] nf;
        settle();
        r = $urandom_range(0, 19);
        if ($urandom_range(0, 2) != 0) begin
            write_reg(CFG_AVG_FACTOR, (r == 0) ? 21'd0 :
                                      (r < 6)  ? 21'd1 :
                                      (r < 16) ? 21'($urandom_range(2, 4)) :
                                                 21'($urandom_range(5, 8)));
        end
        r  = $urandom_range(0, 19);
        nf = (r == 0) ? 21'd0 :
             (r == 1) ? (($urandom_range(0, 1) != 0) ? 21'h1F_FFFF : 21'h10_0000) :
                        21'($urandom_range(1, RND_FRAME_MAX));
        // within a run the frame may only shrink, so no sum is read unwritten
        if (mid_run && eff_frame(nf) > eff_frame(cur_frame)) nf = cur_frame;
        if ($urandom_range(0, 2) != 0) write_reg(CFG_FRAME_PIXELS, nf);
        if ($urandom_range(0, 2) != 0) write_reg(CFG_PIXEL_WIDTH, 21'($urandom_range(0, 3)));
        if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED, 21'($urandom));
        close_writes();
        f = eff_factor(cur_factor);
        n = eff_frame(cur_frame);
        if (n > RND_FRAME_MAX) begin
            count = $urandom_range(1, 20);
        end else begin
            count = f * n * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) count += $urandom_range(1, n);
        end
        if (count > MAX_PHASE_WORDS) count = MAX_PHASE_WORDS;
        repeat (count) begin
            if ($urandom_range(0, 199) == 0) wait_results();
            send_word(pick_sample(cur_wcode));
        end
    endtask

    initial begin
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= CFG_AVG_FACTOR;
        cfg_data        <= '0;
        u_pix_if.valid  <= 1'b0;
        u_pix_if.sample <= '0;
        cur_factor      = 21'(FACTOR_RST);
        cur_frame       = FRAME_RST;
        cur_wcode       = WCODE_RST;
        words_sent      = 0;
        settings_used   = 1;
        calm            = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: pass-through, full-size frame, two-byte pixels
        send_word(32'hDEAD_7FFF);
        send_word(32'h0000_8000);
        send_word(32'hFFFF_0000);

        // zero factor and zero frame size act as 1; position already past the end
        settle();
        write_reg(CFG_FRAME_PIXELS, 21'd0);
        write_reg(CFG_AVG_FACTOR, 21'd0);
        close_writes();
        send_word(32'h1234_5678);
        send_word(32'hFFFF_FFFF);

        // byte pixels, three frames of two, truncation toward zero both ways
        settle();
        write_reg(CFG_PIXEL_WIDTH, 21'(WC_BYTE));
        write_reg(CFG_AVG_FACTOR, 21'd3);
        write_reg(CFG_FRAME_PIXELS, 21'd2);
        close_writes();
        send_word(32'h0000_A57F);
        send_word(32'hFFFF_FF80);
        send_word(32'h1234_567F);
        send_word(32'h0000_0080);
        send_word(32'h0000_007E);
        send_word(32'h0000_0181);

        // four-byte extremes, sums past 32 bits
        settle();
        write_reg(CFG_PIXEL_WIDTH, 21'(WC_WORD));
        write_reg(CFG_AVG_FACTOR, 21'd2);
        close_writes();
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h8000_0001);

        // width code 3, oversized frame saturates
        settle();
        write_reg(CFG_PIXEL_WIDTH, 21'(WC_WORD_ALT));
        write_reg(CFG_FRAME_PIXELS, 21'h1F_FFFF);
        write_reg(CFG_AVG_FACTOR, 21'd1);
        close_writes();
        send_word(32'h8000_0000);
        send_word(32'h7FFF_FFFF);
        send_word(32'h0000_0001);

        // shrink the frame under the position, then cut a long run short
        settle();
        write_reg(CFG_FRAME_PIXELS, 21'd1);
        write_reg(CFG_AVG_FACTOR, 21'(MAX_AVERAGE_FACTOR_DEF));
        write_reg(CFG_UNUSED, 21'h1F_FFFF);
        close_writes();
        send_word(32'h7FFF_FFFF);
        send_word(32'h7FFF_FFFF);
        send_word(32'hFFFF_FFFE);
        settle();
        write_reg(CFG_AVG_FACTOR, 21'd2);
        close_writes();
        send_word(32'h0000_0003);

        // oversized factor saturates; full-depth negative sum
        settle();
        write_reg(CFG_AVG_FACTOR, 21'h1F_FFFF);
        write_reg(CFG_PIXEL_WIDTH, 21'(WC_WORD));
        close_writes();
        repeat (MAX_AVERAGE_FACTOR_DEF) send_word(32'h8000_0000);

        while (words_sent < TOTAL_WORDS) random_phase();

        u_pix_if.valid <= 1'b0;
        for (int i = 0; i < END_LIMIT && pending != 0; i++) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending != 0) $display("%0d averaged pixels never arrived", pending);
        $display("%0d sample words in, %0d averaged pixels compared over %0d register settings",
                 words_sent, results, settings_used);
        $display("factors 1 to the 1024 ceiling, frames of 1 to full size, all pixel widths");
        if (err_total == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
